>>> hdl/vtm_pkg.sv
// ----------------------------------------------------------------------------
// vtm_pkg
// shared field widths, request, result and status codes of the timer block
// ----------------------------------------------------------------------------
package vtm_pkg;

	localparam int REQ_TYPE_W = 2;
	localparam int DUR_W      = 32;
	localparam int SLOT_W     = 4;
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int EXP_W      = 32;

	// most timers that fire on one tick
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int QIDX_W      = $clog2(MAX_RESULTS);

	localparam logic [REQ_TYPE_W-1:0] REQ_TICK   = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_START  = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_CANCEL = 2'd2;

	localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

	// control of the shared compare unit
	typedef struct packed {
		logic clr;
		logic cand;
	} vtm_cmp_ctl_t;

endpackage

>>> hdl/vtm_if.sv
// ----------------------------------------------------------------------------
// vtm_if
// request and response channels of the timer block, valid/ready handshake
// ----------------------------------------------------------------------------
interface vtm_req_if import vtm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [DUR_W-1:0]      duration;
	logic                  repeat_req;
	logic [SLOT_W-1:0]     cancel_slot;

	modport source (output valid, req_type, duration, repeat_req, cancel_slot, input ready);
	modport sink (input valid, req_type, duration, repeat_req, cancel_slot, output ready);
endinterface

interface vtm_rsp_if import vtm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   result_kind;
	logic [SLOT_W-1:0]   slot_id;
	logic [STATUS_W-1:0] status;
	logic [EXP_W-1:0]    earliest_expiry;
	logic                any_active;
	logic                last_of_run;

	modport source (output valid, result_kind, slot_id, status, earliest_expiry, any_active,
		last_of_run, input ready);
	modport sink (input valid, result_kind, slot_id, status, earliest_expiry, any_active,
		last_of_run, output ready);
endinterface

>>> hdl/virtual_timer_multiplexer.sv
// ----------------------------------------------------------------------------
// virtual_timer_multiplexer
// NUM_TIMERS virtual timers on one request-stepped tick counter, one shared
// compare unit scans the slot table for due timers and the earliest expiry
// ----------------------------------------------------------------------------
// one item at a time, ready only while idle. a scan reads the expiry ram slot by
// slot through its single read port. start and cancel run one scan each, a tick
// with F fired timers runs F + 2 scans, one scan less when nothing fires or when
// MAX_RESULTS fire; then one result item per cycle while rsp.ready is high.
// reset clears the counter and all active bits at once, no clearing pass;
// expiry and period rams are left unset.
// ----------------------------------------------------------------------------
module virtual_timer_multiplexer import vtm_pkg::*; #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	vtm_req_if.sink   req,
	vtm_rsp_if.source rsp
);
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_POST = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	// what a scan looks for
	localparam logic [1:0] M_DUE   = 2'd0; // first pass of a tick, marks due slots
	localparam logic [1:0] M_PICK  = 2'd1; // earliest remaining due slot
	localparam logic [1:0] M_MIN   = 2'd2; // earliest expiry over active slots
	localparam logic [1:0] M_START = 2'd3; // earliest expiry plus lowest free slot

	logic [1:0]            state_q;
	logic [1:0]            mode_q;
	logic [TIME_WIDTH-1:0] time_q;
	logic [NUM_TIMERS-1:0] active_q;
	logic [NUM_TIMERS-1:0] due_q;
	logic [NUM_TIMERS-1:0] repeat_q;

	// latched request and single-result fields
	logic [REQ_TYPE_W-1:0] op_q;
	logic [TIME_WIDTH-1:0] dur_q;
	logic                  rep_req_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic [STATUS_W-1:0]   res_status_q;

	// fired slots of one tick, in firing order
	logic [SLOT_W-1:0] fire_q [MAX_RESULTS];
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rd_q;

	// scan address counter and read pipeline
	logic [IDX_W-1:0] scan_q;
	logic             issue_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [TIME_WIDTH-1:0] best_rel_q;

	logic                  accept_in;
	logic [IDX_W-1:0]      cancel_idx;
	logic                  cancel_hit;
	logic [TIME_WIDTH-1:0] exp_rd;
	logic [TIME_WIDTH-1:0] rel_rd;
	logic                  due_now;
	logic                  scan_cand;
	logic [TIME_WIDTH-1:0] add_a;
	logic [TIME_WIDTH-1:0] add_b;
	logic [TIME_WIDTH-1:0] sum;
	logic                  fire;
	logic                  start_ok;
	logic                  launch;
	logic [1:0]            launch_mode;
	logic                  exp_we;
	logic [IDX_W-1:0]      exp_waddr;

	vtm_cmp_ctl_t          cmp_ctl;
	logic [TIME_WIDTH-1:0] cmp_val;
	logic [IDX_W-1:0]      cmp_idx;
	logic                  found;
	logic [TIME_WIDTH-1:0] best_val;
	logic [IDX_W-1:0]      best_idx;
	logic                  take;

	assign req.ready = (state_q == S_IDLE);
	assign accept_in = req.valid && req.ready;

	// cancel lookup happens right at accept
	assign cancel_idx = IDX_W'(req.cancel_slot);
	assign cancel_hit = (32'(req.cancel_slot) < 32'(NUM_TIMERS)) && active_q[cancel_idx];

	// due test against the already advanced counter
	assign due_now = active_q[idx_s1] && (exp_rd <= time_q);

	always_comb begin
		case (mode_q)
			M_DUE:   scan_cand = due_now;
			M_PICK:  scan_cand = due_q[idx_s1];
			M_MIN:   scan_cand = active_q[idx_s1];
			M_START: scan_cand = active_q[idx_s1];
			default: scan_cand = 1'b0;
		endcase
	end

	// one shared adder: tick increment, start expiry, periodic reload
	always_comb begin
		if (state_q == S_IDLE) begin
			add_a = time_q;
			add_b = TIME_WIDTH'(1);
		end else if (mode_q == M_START) begin
			add_a = time_q;
			add_b = dur_q;
		end else begin
			add_a = best_val;
			add_b = best_rel_q;
		end
	end
	assign sum = add_a + add_b;

	assign fire     = (state_q == S_POST) && ((mode_q == M_DUE) || (mode_q == M_PICK)) && found;
	assign start_ok = (state_q == S_POST) && (mode_q == M_START) && free_found_q;

	// when to start a fresh scan and of which kind
	always_comb begin
		launch      = 1'b0;
		launch_mode = M_MIN;
		case (state_q)
			S_IDLE: begin
				if (accept_in) begin
					case (req.req_type)
						REQ_TICK: begin
							launch      = 1'b1;
							launch_mode = M_DUE;
						end
						REQ_START: begin
							launch      = 1'b1;
							launch_mode = M_START;
						end
						REQ_CANCEL: begin
							launch      = 1'b1;
							launch_mode = M_MIN;
						end
						default: launch = 1'b0;
					endcase
				end
			end
			S_POST: begin
				if ((mode_q == M_DUE) || (mode_q == M_PICK)) begin
					if (found) begin
						launch      = 1'b1;
						launch_mode = (CNT_W'(cnt_q + 1'b1) == CNT_W'(MAX_RESULTS)) ? M_MIN
							: M_PICK;
					end else if (cnt_q != '0) begin
						launch      = 1'b1;
						launch_mode = M_MIN;
					end
				end
			end
			default: launch = 1'b0;
		endcase
	end

	// expiry ram written on start and on reload of a periodic timer
	assign exp_we    = start_ok || (fire && repeat_q[best_idx]);
	assign exp_waddr = start_ok ? free_idx_q : best_idx;

	vtm_ram #(
		.WIDTH (TIME_WIDTH),
		.DEPTH (NUM_TIMERS)
	) u_exp_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (exp_waddr),
		.wdata (sum),
		.raddr (scan_q),
		.rdata (exp_rd)
	);

	vtm_ram #(
		.WIDTH (TIME_WIDTH),
		.DEPTH (NUM_TIMERS)
	) u_rel_ram (
		.clk   (clk),
		.we    (start_ok),
		.waddr (free_idx_q),
		.wdata (dur_q),
		.raddr (scan_q),
		.rdata (rel_rd)
	);

	// compare unit takes ram data while scanning, and the new expiry of a start
	assign cmp_ctl.clr  = launch;
	assign cmp_ctl.cand = ((state_q == S_SCAN) && vld_s1 && scan_cand) || start_ok;
	assign cmp_val      = (state_q == S_SCAN) ? exp_rd : sum;
	assign cmp_idx      = (state_q == S_SCAN) ? idx_s1 : free_idx_q;

	vtm_min_unit #(
		.VAL_W (TIME_WIDTH),
		.IDX_W (IDX_W)
	) u_min (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (cmp_ctl),
		.val      (cmp_val),
		.idx      (cmp_idx),
		.found    (found),
		.best_val (best_val),
		.best_idx (best_idx),
		.take     (take)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= M_MIN;
			time_q       <= '0;
			active_q     <= '0;
			cnt_q        <= '0;
			rd_q         <= '0;
			scan_q       <= '0;
			issue_q      <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						case (req.req_type)
							REQ_TICK: begin
								time_q <= sum;
								cnt_q  <= '0;
							end
							REQ_START: cnt_q <= CNT_W'(1);
							REQ_CANCEL: begin
								cnt_q <= CNT_W'(1);
								if (cancel_hit) begin
									active_q[cancel_idx] <= 1'b0;
								end
							end
							default: cnt_q <= cnt_q;
						endcase
					end
				end
				S_SCAN: begin
					// the last index is in flight with issue already stopped
					if (issue_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= scan_q;
						if (scan_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end else begin
						vld_s1 <= 1'b0;
					end
					// lowest free slot for a start
					if (vld_s1 && (mode_q == M_START) && !active_q[idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_s1;
					end
					if (vld_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					case (mode_q)
						M_DUE, M_PICK: begin
							if (found) begin
								cnt_q <= cnt_q + 1'b1;
								if (!repeat_q[best_idx]) begin
									active_q[best_idx] <= 1'b0;
								end
							end else if (cnt_q == '0) begin
								state_q <= S_IDLE;
							end
						end
						M_START: begin
							if (free_found_q) begin
								active_q[free_idx_q] <= 1'b1;
							end
							rd_q    <= '0;
							state_q <= S_EMIT;
						end
						default: begin
							rd_q    <= '0;
							state_q <= S_EMIT;
						end
					endcase
				end
				S_EMIT: begin
					if (rsp.ready) begin
						if (rsp.last_of_run) begin
							state_q <= S_IDLE;
						end else begin
							rd_q <= rd_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (launch) begin
				state_q      <= S_SCAN;
				mode_q       <= launch_mode;
				scan_q       <= '0;
				issue_q      <= 1'b1;
				vld_s1       <= 1'b0;
				free_found_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept_in) begin
			op_q         <= req.req_type;
			dur_q        <= TIME_WIDTH'(req.duration);
			rep_req_q    <= req.repeat_req;
			res_slot_q   <= req.cancel_slot;
			res_status_q <= cancel_hit ? ST_OK : ST_NOT_ACTIVE;
		end
		if ((state_q == S_SCAN) && take) begin
			best_rel_q <= rel_rd;
		end
		if ((state_q == S_SCAN) && vld_s1 && (mode_q == M_DUE)) begin
			due_q[idx_s1] <= due_now;
		end
		if (fire) begin
			due_q[best_idx]                 <= 1'b0;
			fire_q[cnt_q[QIDX_W-1:0]]       <= SLOT_W'(best_idx);
		end
		if ((state_q == S_POST) && (mode_q == M_START)) begin
			if (free_found_q) begin
				repeat_q[free_idx_q] <= rep_req_q;
				res_slot_q           <= SLOT_W'(free_idx_q);
				res_status_q         <= ST_OK;
			end else begin
				res_slot_q   <= '0;
				res_status_q <= ST_FULL;
			end
		end
	end

	// result items, all taken from registers
	assign rsp.valid           = (state_q == S_EMIT);
	assign rsp.result_kind     = (op_q == REQ_TICK) ? KIND_FIRED
		: ((op_q == REQ_START) ? KIND_START : KIND_CANCEL);
	assign rsp.slot_id         = (op_q == REQ_TICK) ? fire_q[rd_q[QIDX_W-1:0]] : res_slot_q;
	assign rsp.status          = (op_q == REQ_TICK) ? ST_OK : res_status_q;
	assign rsp.earliest_expiry = found ? EXP_W'(best_val) : '0;
	assign rsp.any_active      = found;
	assign rsp.last_of_run     = (rd_q == CNT_W'(cnt_q - 1'b1));

	// earliest-expiry search agrees with the active table
	a_any_active: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.any_active == (|active_q)))
		else $error("any_active disagrees with active table");

	// fire list never overflows
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("fire count beyond limit");

	// last item of a run returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && rsp.last_of_run) |=> req.ready)
		else $error("not idle after last item");

	// an accepted request is worked on before the next is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_in && (req.req_type == REQ_TICK || req.req_type == REQ_START
			|| req.req_type == REQ_CANCEL)) |=> !req.ready)
		else $error("ready while busy");
endmodule

>>> hdl/vtm_ram.sv
// ----------------------------------------------------------------------------
// vtm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module vtm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> hdl/vtm_min_unit.sv
// ----------------------------------------------------------------------------
// vtm_min_unit
// shared compare unit, keeps the smallest value seen and its index
// ----------------------------------------------------------------------------
module vtm_min_unit import vtm_pkg::*; #(
	parameter int VAL_W = 32,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  vtm_cmp_ctl_t     ctl,
	input  logic [VAL_W-1:0] val,
	input  logic [IDX_W-1:0] idx,
	output logic             found,
	output logic [VAL_W-1:0] best_val,
	output logic [IDX_W-1:0] best_idx,
	output logic             take
);
	logic             found_q;
	logic [VAL_W-1:0] best_val_q;
	logic [IDX_W-1:0] best_idx_q;

	// strict less keeps the first entry seen on ties; scan entries rise by index
	assign take = ctl.cand && (!found_q || (val < best_val_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clr && take) begin
			best_val_q <= val;
			best_idx_q <= idx;
		end
	end

	assign found    = found_q;
	assign best_val = best_val_q;
	assign best_idx = best_idx_q;
endmodule

>>> sim/vtm_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtm_result_checker
// watches both channels of the timer block, keeps its own copy of the slot
// table and tick counter, and compares every result item against the oldest
// predicted one
// ----------------------------------------------------------------------------
module vtm_result_checker import vtm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	vtm_req_if   req,
	vtm_rsp_if   rsp,
	output int   pending,
	output int   errors
);

	localparam int NUM_SLOTS = 16;

	typedef struct packed {
		logic [KIND_W-1:0]   result_kind;
		logic [SLOT_W-1:0]   slot_id;
		logic [STATUS_W-1:0] status;
		logic [EXP_W-1:0]    earliest_expiry;
		logic                any_active;
		logic                last_of_run;
	} timer_result_t;

	// mirror of the slot table
	logic [EXP_W-1:0]     now_ticks;
	logic [NUM_SLOTS-1:0] slot_busy;
	logic [EXP_W-1:0]     slot_expiry [NUM_SLOTS];
	logic [DUR_W-1:0]     slot_period [NUM_SLOTS];
	logic                 slot_reloads [NUM_SLOTS];

	timer_result_t awaited_results [$];

	function automatic timer_result_t result_head(logic [KIND_W-1:0] kind,
		logic [SLOT_W-1:0] slot, logic [STATUS_W-1:0] st);
		timer_result_t r;
		r = '0;
		r.result_kind = kind;
		r.slot_id     = slot;
		r.status      = st;
		return r;
	endfunction

	// one request applied to the mirrored table, its result items queued
	task automatic timer_table_step(logic [REQ_TYPE_W-1:0] kind, logic [DUR_W-1:0] dur,
		logic rpt, logic [SLOT_W-1:0] id);
		timer_result_t        step_out [$];
		logic [NUM_SLOTS-1:0] due_mask;
		logic [EXP_W-1:0]     best;
		logic                 seen;
		int                   free_slot;
		int                   pick;
		case (kind)
			REQ_START: begin
				free_slot = -1;
				for (int i = 0; i < NUM_SLOTS; i++)
					if (!slot_busy[i] && free_slot < 0) free_slot = i;
				if (free_slot < 0) begin
					step_out.push_back(result_head(KIND_START, '0, ST_FULL));
				end else begin
					slot_busy[free_slot]    = 1'b1;
					slot_period[free_slot]  = dur;
					slot_expiry[free_slot]  = now_ticks + dur;
					slot_reloads[free_slot] = rpt;
					step_out.push_back(result_head(KIND_START, SLOT_W'(free_slot), ST_OK));
				end
			end
			REQ_CANCEL: begin
				if (slot_busy[id]) begin
					slot_busy[id] = 1'b0;
					step_out.push_back(result_head(KIND_CANCEL, id, ST_OK));
				end else begin
					step_out.push_back(result_head(KIND_CANCEL, id, ST_NOT_ACTIVE));
				end
			end
			REQ_TICK: begin
				now_ticks = now_ticks + 1'b1;
				for (int i = 0; i < NUM_SLOTS; i++)
					due_mask[i] = slot_busy[i] && (slot_expiry[i] <= now_ticks);
				// earliest expiry first, lowest slot on a tie
				while (step_out.size() < MAX_RESULTS) begin
					pick = -1;
					for (int i = 0; i < NUM_SLOTS; i++)
						if (due_mask[i] && (pick < 0 || slot_expiry[i] < slot_expiry[pick]))
							pick = i;
					if (pick < 0) break;
					due_mask[pick] = 1'b0;
					if (slot_reloads[pick])
						slot_expiry[pick] = slot_expiry[pick] + slot_period[pick];
					else
						slot_busy[pick] = 1'b0;
					step_out.push_back(result_head(KIND_FIRED, SLOT_W'(pick), ST_OK));
				end
			end
			default: ;
		endcase
		best = '0;
		seen = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (slot_busy[i] && (!seen || slot_expiry[i] < best)) begin
				best = slot_expiry[i];
				seen = 1'b1;
			end
		foreach (step_out[k]) begin
			step_out[k].earliest_expiry = best;
			step_out[k].any_active      = seen;
			step_out[k].last_of_run     = (k == step_out.size() - 1);
			awaited_results.push_back(step_out[k]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_result_t got;
		timer_result_t want;
		if (!arst_n) begin
			now_ticks = '0;
			slot_busy = '0;
			awaited_results.delete();
			pending <= 0;
			errors  <= 0;
		end else begin
			// results first, they belong to requests already taken
			if (rsp.valid && rsp.ready) begin
				got.result_kind     = rsp.result_kind;
				got.slot_id         = rsp.slot_id;
				got.status          = rsp.status;
				got.earliest_expiry = rsp.earliest_expiry;
				got.any_active      = rsp.any_active;
				got.last_of_run     = rsp.last_of_run;
				if (awaited_results.size() == 0) begin
					$display("%0t: extra item kind %0d slot %0d st %0d exp %h act %0b last %0b",
						$time, got.result_kind, got.slot_id, got.status, got.earliest_expiry,
						got.any_active, got.last_of_run);
					errors <= errors + 1;
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						$display("%0t: expected kind %0d slot %0d st %0d exp %h act %0b last %0b",
							$time, want.result_kind, want.slot_id, want.status,
							want.earliest_expiry, want.any_active, want.last_of_run);
						$display("%0t: actual kind %0d slot %0d st %0d exp %h act %0b last %0b",
							$time, got.result_kind, got.slot_id, got.status,
							got.earliest_expiry, got.any_active, got.last_of_run);
						errors <= errors + 1;
					end
				end
			end
			if (req.valid && req.ready)
				timer_table_step(req.req_type, req.duration, req.repeat_req, req.cancel_slot);
			pending <= awaited_results.size();
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives start, cancel and tick requests into the virtual timer block under
// several idle and stall mixes; a side checker predicts every result item
// ----------------------------------------------------------------------------
module testbench import vtm_pkg::*;;

	// the limit covers every item at its worst scan cost with both sides stalling
	localparam int LIMIT_CYCLES   = 700000;
	localparam int DRAIN_CYCLES   = 400;
	localparam int ITEMS_PER_MIX  = 75;
	localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   pending;
	int   errors;
	int   cycle_count = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;

	vtm_req_if req_ch ();
	vtm_rsp_if rsp_ch ();

	virtual_timer_multiplexer #(
		.NUM_TIMERS(16),
		.TIME_WIDTH(32)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	vtm_result_checker result_check (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.pending(pending),
		.errors (errors)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// response side back-pressure, redrawn every cycle
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// hard stop if the block hangs or loses results
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// present one request item and hold it until the block takes it; valid
	// only drops when a gap is drawn, so back-to-back items keep it high
	task automatic post_request(logic [REQ_TYPE_W-1:0] kind, logic [DUR_W-1:0] dur,
		logic rpt, logic [SLOT_W-1:0] id);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= kind;
		req_ch.duration    <= dur;
		req_ch.repeat_req  <= rpt;
		req_ch.cancel_slot <= id;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// mostly short periods so timers actually expire, some medium ones, and a
	// few full-width values that park a slot or wrap the expiry sum
	function automatic logic [DUR_W-1:0] pick_period();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return DUR_W'($urandom_range(0, 12));
		else if (roll < 90) return DUR_W'($urandom_range(13, 80));
		else return $urandom();
	endfunction

	initial begin
		int roll;
		int taken;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_TICK;
		req_ch.duration    <= '0;
		req_ch.repeat_req  <= 1'b0;
		req_ch.cancel_slot <= '0;
		arst_n             <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling on either side
		// tick on an empty table gives no result
		post_request(REQ_TICK, '0, 1'b0, '0);
		// cancel of a slot that was never started
		post_request(REQ_CANCEL, '0, 1'b0, 4'd5);
		// unused request code, all other fields high, must be ignored
		post_request(REQ_UNUSED, '1, 1'b1, '1);
		// zero-period repeating timer, expiry already due, waits for next tick
		post_request(REQ_START, '0, 1'b1, '0);
		// largest duration, the expiry sum wraps below the current time
		post_request(REQ_START, '1, 1'b0, '0);
		// fill the rest of the table with timers due on the next tick
		for (int i = 2; i < 16; i++)
			post_request(REQ_START, 32'd1, i[0], '1);
		// table full
		post_request(REQ_START, 32'd7, 1'b1, '0);
		// every slot fires on one tick, wrapped one first, then by expiry and slot
		post_request(REQ_TICK, '1, 1'b1, '1);
		// cancel a live repeating timer, then a one-shot that already fired
		post_request(REQ_CANCEL, '1, 1'b1, 4'd0);
		post_request(REQ_CANCEL, '0, 1'b0, 4'd1);
		// reloaded timers fire again
		post_request(REQ_TICK, '0, 1'b0, '0);
		post_request(REQ_CANCEL, '1, 1'b0, 4'd15);

		// random part, four idle/stall mixes
		for (int mix = 0; mix < 4; mix++) begin
			case (mix)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 50; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 50; end
				default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			taken = 0;
			while (taken < ITEMS_PER_MIX) begin
				roll = $urandom_range(0, 99);
				// unused fields carry random content so every bit moves
				if (roll < 5) begin
					post_request(REQ_UNUSED, $urandom(), 1'($urandom()), 4'($urandom()));
				end else if (roll < 50) begin
					post_request(REQ_TICK, $urandom(), 1'($urandom()), 4'($urandom()));
					taken++;
				end else if (roll < 80) begin
					post_request(REQ_START, pick_period(), 1'($urandom()), 4'($urandom()));
					taken++;
				end else begin
					post_request(REQ_CANCEL, $urandom(), 1'($urandom()), 4'($urandom()));
					taken++;
				end
			end
		end
		req_ch.valid <= 1'b0;

		// wait for every predicted item, then watch for stray ones
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
